/* sv/hfd_pkg.sv */
package hfd_pkg;

    localparam int FRAC_W    = 56;
    localparam int HEXP_W    = 7;
    localparam int MANT_W    = 52;
    localparam int BEXP_W    = 11;
    localparam int POS_W     = 6;
    localparam int EXP_OFFSET = 711;

    // Stage 2 to stage 3: normalized fraction and exponent
    typedef struct packed {
        logic              sign;
        logic              zero;
        logic [BEXP_W-1:0] bexp;
        logic [FRAC_W-1:0] norm;   // leading one at bit FRAC_W-1
    } hfd_norm_t;

    // Stage 3 output: packed result
    typedef struct packed {
        logic [63:0] bits;
    } hfd_res_t;

endpackage

/* sv/hex_float_to_double_convert.sv */
// Converts one 64-bit base-16 excess-64 real word (sign, 7-bit exponent,
// 56-bit fraction, need not be normalized) to the IEEE 754 binary64 pattern,
// rounding to nearest even. Three register stages: input word with the
// leading-one position of its fraction, normalize (shift and exponent),
// round and pack. One word per cycle; m_valid rises once the word has
// passed the input, normalize and round registers in that order.
// A stalled output holds the whole pipeline. A zero fraction gives a zero
// carrying the input sign.
module hex_float_to_double_convert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_hex_real,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_double_bits
);
    import hfd_pkg::*;

    logic             v0_reg, v1_reg, v2_reg;
    logic             en0, en1, en2;
    logic [63:0]      word_reg;
    logic [POS_W-1:0] msb_next;
    logic [POS_W-1:0] msb_reg;
    hfd_norm_t        norm_reg;
    hfd_res_t         res_reg;

    // advance each stage when the next one is free
    assign en2 = !v2_reg || m_ready;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign s_ready = en0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en0) v0_reg <= s_valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
        end
    end

    // find leading one of the incoming fraction
    always_comb begin
        msb_next = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            if (s_hex_real[i]) begin
                msb_next = POS_W'(i);
            end
        end
    end

    // capture input word and its leading-one position
    always_ff @(posedge aclk) begin
        if (en0) begin
            word_reg <= s_hex_real;
            msb_reg  <= msb_next;
        end
    end

    hfd_norm u_norm (
        .aclk     (aclk),
        .en       (en1),
        .word     (word_reg),
        .msb      (msb_reg),
        .norm_reg (norm_reg)
    );

    hfd_round u_round (
        .aclk    (aclk),
        .en      (en2),
        .norm    (norm_reg),
        .res_reg (res_reg)
    );

    assign m_valid       = v2_reg;
    assign m_double_bits = res_reg.bits;

    // a stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_double_bits))
        else $error("output word changed under stall");
    // ready only drops when the output is stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");
    // a word in stage 2 moves on when output is free
    a_move: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && m_ready |=> m_valid)
        else $error("word lost between stages");

endmodule

/* sv/hfd_norm.sv */
module hfd_norm (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [63:0]                word,
    input  logic [hfd_pkg::POS_W-1:0]  msb,
    output hfd_pkg::hfd_norm_t         norm_reg
);
    import hfd_pkg::*;

    logic [FRAC_W-1:0] frac;
    logic [POS_W-1:0]  lz;
    hfd_norm_t         norm_next;

    assign frac = word[FRAC_W-1:0];

    assign lz = POS_W'(FRAC_W - 1) - msb;

    // normalize and form biased exponent
    always_comb begin
        norm_next.sign = word[63];
        norm_next.zero = (frac == '0);
        norm_next.bexp = BEXP_W'(msb) + BEXP_W'({word[62:56], 2'b00})
                         + BEXP_W'(EXP_OFFSET);
        norm_next.norm = frac << lz;
    end

    // hold on stall
    always_ff @(posedge aclk) begin
        if (en) begin
            norm_reg <= norm_next;
        end
    end

endmodule

/* sv/hfd_round.sv */
module hfd_round (
    input  logic                aclk,
    input  logic                en,
    input  hfd_pkg::hfd_norm_t  norm,
    output hfd_pkg::hfd_res_t   res_reg
);
    import hfd_pkg::*;

    logic [MANT_W:0]   mant;
    logic [2:0]        low;
    logic              rnd_up;
    logic [MANT_W+1:0] sum;
    logic [BEXP_W-1:0] bexp;
    hfd_res_t          res_next;

    // keep 53 bits, guard bit and sticky from the low 3
    assign mant   = norm.norm[FRAC_W-1 -: MANT_W+1];
    assign low    = norm.norm[2:0];
    assign rnd_up = low[2] & ((|low[1:0]) | mant[0]);
    assign sum    = {1'b0, mant} + (MANT_W+2)'(rnd_up);

    always_comb begin
        bexp = norm.bexp;
        res_next.bits = {norm.sign, bexp, sum[MANT_W-1:0]};
        if (sum[MANT_W+1]) begin
            bexp = norm.bexp + BEXP_W'(1);
            res_next.bits = {norm.sign, bexp, sum[MANT_W:1]};
        end
        if (norm.zero) begin
            res_next.bits = {norm.sign, 63'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

endmodule
